### rtl/core/fpv_pkg.sv
// Package for the fixed-point vector ALU: operation codes, widths and the
// item record that travels down the pipeline. No dependencies.
package fpv_pkg;

   localparam int FRAC_BITS_DEF = 12;
   localparam int WORD_W = 32;
   localparam int FUNC_W = 4;
   localparam int LANES = 3;

   localparam logic [FUNC_W-1:0] FN_ADD   = 4'd0;
   localparam logic [FUNC_W-1:0] FN_SUB   = 4'd1;
   localparam logic [FUNC_W-1:0] FN_SCALE = 4'd2;
   localparam logic [FUNC_W-1:0] FN_MUL   = 4'd3;
   localparam logic [FUNC_W-1:0] FN_DIV   = 4'd4;
   localparam logic [FUNC_W-1:0] FN_DIVS  = 4'd5;
   localparam logic [FUNC_W-1:0] FN_MAG2  = 4'd6;
   localparam logic [FUNC_W-1:0] FN_MAG   = 4'd7;
   localparam logic [FUNC_W-1:0] FN_NORM  = 4'd8;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      word_type [LANES-1:0] a;
      word_type [LANES-1:0] b;
      word_type             s;
      word_type [LANES-1:0] prod;
      word_type             mag2;
      word_type             root;
      word_type [LANES-1:0] quot;
      logic [LANES-1:0]     dzl;
   } item_type;

endpackage

### rtl/core/fpv_if.sv
// Valid/ready channel interfaces for the vector ALU request and response items.
// Depends on nothing.
interface fpv_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         func;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;
   logic signed [31:0] scalar_operand;
   modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scalar_operand,
                   input ready);
   modport sink (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scalar_operand,
                 output ready);
endinterface

interface fpv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] r_x;
   logic signed [31:0] r_y;
   logic signed [31:0] r_z;
   logic signed [31:0] scalar_result;
   logic               div_zero;
   modport source (output valid, r_x, r_y, r_z, scalar_result, div_zero, input ready);
   modport sink (input valid, r_x, r_y, r_z, scalar_result, div_zero, output ready);
endinterface

### rtl/core/fpv_mult.sv
// Two-stage multiply unit: three 32x32 products, then the fixed-point shift
// and the wrapped sum of squares. Depends on fpv_pkg.
module fpv_mult #(
   parameter int FRAC_BITS = fpv_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  logic              in_valid,
   input  fpv_pkg::item_type in_item,
   output logic              out_valid,
   output fpv_pkg::item_type out_item
);
   import fpv_pkg::*;

   logic signed [63:0] p_in [LANES];
   logic signed [63:0] p_ff [LANES];
   item_type           item1_ff;
   logic               v1_ff;
   item_type           item2_in;
   item_type           item2_ff;
   logic               v2_ff;

   always_comb begin
      word_type m;
      for (int i = 0; i < LANES; i++) begin
         if (in_item.func == FN_SCALE) begin
            m = in_item.s;
         end else if (in_item.func == FN_MUL) begin
            m = in_item.b[i];
         end else begin
            m = in_item.a[i];
         end
         p_in[i] = $signed(in_item.a[i]) * $signed(m);
      end
   end

   always_comb begin
      logic signed [63:0] q;
      item2_in = item1_ff;
      item2_in.mag2 = '0;
      for (int i = 0; i < LANES; i++) begin
         q = p_ff[i] >>> FRAC_BITS;
         item2_in.prod[i] = q[31:0];
         item2_in.mag2 = item2_in.mag2 + q[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (ce) begin
         p_ff     <= p_in;
         item1_ff <= in_item;
         item2_ff <= item2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = item2_ff;

endmodule

### rtl/core/fpv_sqrt.sv
// Pipelined floor square root of the sum of squares shifted left by the
// fraction bits, one root bit per stage. Depends on fpv_pkg.
module fpv_sqrt #(
   parameter int FRAC_BITS = fpv_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  logic              in_valid,
   input  fpv_pkg::item_type in_item,
   output logic              out_valid,
   output fpv_pkg::item_type out_item
);
   import fpv_pkg::*;

   localparam int VW  = WORD_W + FRAC_BITS;
   localparam int EW  = VW + (VW % 2);
   localparam int RW  = EW / 2;
   localparam int RMW = RW + 3;

   logic [EW-1:0]  x_s    [RW+1];
   logic [RMW-1:0] rem_s  [RW+1];
   logic [RW-1:0]  root_s [RW+1];
   item_type       item_s [RW+1];
   logic           v_s    [RW+1];

   assign x_s[0]    = EW'({in_item.mag2, {FRAC_BITS{1'b0}}});
   assign rem_s[0]  = '0;
   assign root_s[0] = '0;
   assign item_s[0] = in_item;
   assign v_s[0]    = in_valid;

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RMW-1:0] rem_sh;
      logic [RMW-1:0] trial;
      logic [RMW-1:0] rem_in;
      logic [RW-1:0]  root_in;
      logic [RMW-1:0] rem_ff;
      logic [RW-1:0]  root_ff;
      logic [EW-1:0]  x_ff;
      item_type       item_ff;
      logic           v_ff;

      always_comb begin
         rem_sh = {rem_s[k][RMW-3:0], x_s[k][EW-1:EW-2]};
         trial  = RMW'({root_s[k], 2'b01});
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_s[k][RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_s[k][RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (ce) begin
            v_ff <= v_s[k];
         end
         if (ce) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            x_ff    <= x_s[k] << 2;
            item_ff <= item_s[k];
         end
      end

      assign rem_s[k+1]  = rem_ff;
      assign root_s[k+1] = root_ff;
      assign x_s[k+1]    = x_ff;
      assign item_s[k+1] = item_ff;
      assign v_s[k+1]    = v_ff;
   end

   always_comb begin
      out_item      = item_s[RW];
      out_item.root = WORD_W'(root_s[RW]);
   end
   assign out_valid = v_s[RW];

endmodule

### rtl/core/fpv_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage, with a
// sign and zero-divisor setup stage. Depends on fpv_pkg.
module fpv_div #(
   parameter int FRAC_BITS = fpv_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  logic              in_valid,
   input  fpv_pkg::item_type in_item,
   output logic              out_valid,
   output fpv_pkg::item_type out_item
);
   import fpv_pkg::*;

   localparam int NW = WORD_W + FRAC_BITS;

   logic [NW-1:0]     n_s    [LANES][NW+1];
   logic [WORD_W:0]   rem_s  [LANES][NW+1];
   logic [WORD_W-1:0] d_s    [LANES][NW+1];
   logic              neg_s  [LANES][NW+1];
   logic              zero_s [LANES][NW+1];
   item_type          item_s [NW+1];
   logic              v_s    [NW+1];

   item_type item0_ff;
   logic     v0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (ce) begin
         v0_ff <= in_valid;
      end
      if (ce) begin
         item0_ff <= in_item;
      end
   end

   assign item_s[0] = item0_ff;
   assign v_s[0]    = v0_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      word_type          sd;
      word_type          na;
      word_type          nd;
      logic [NW-1:0]     n0_ff;
      logic [WORD_W-1:0] d0_ff;
      logic              neg0_ff;
      logic              zero0_ff;

      always_comb begin
         if (in_item.func == FN_DIV) begin
            sd = in_item.b[l];
         end else if (in_item.func == FN_NORM) begin
            sd = in_item.root;
         end else begin
            sd = in_item.s;
         end
         na = in_item.a[l][WORD_W-1] ? -in_item.a[l] : in_item.a[l];
         nd = sd[WORD_W-1] ? -sd : sd;
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            n0_ff    <= {na, {FRAC_BITS{1'b0}}};
            d0_ff    <= nd;
            neg0_ff  <= in_item.a[l][WORD_W-1] ^ sd[WORD_W-1];
            zero0_ff <= (sd == '0);
         end
      end

      assign n_s[l][0]    = n0_ff;
      assign rem_s[l][0]  = '0;
      assign d_s[l][0]    = d0_ff;
      assign neg_s[l][0]  = neg0_ff;
      assign zero_s[l][0] = zero0_ff;

      for (genvar k = 0; k < NW; k++) begin : g_stage
         logic [WORD_W:0]   rem_sh;
         logic [WORD_W:0]   rem_in;
         logic              qbit;
         logic [NW-1:0]     n_ff;
         logic [WORD_W:0]   rem_ff;
         logic [WORD_W-1:0] d_ff;
         logic              neg_ff;
         logic              zero_ff;

         always_comb begin
            rem_sh = {rem_s[l][k][WORD_W-1:0], n_s[l][k][NW-1]};
            if (rem_sh >= {1'b0, d_s[l][k]}) begin
               rem_in = rem_sh - {1'b0, d_s[l][k]};
               qbit   = 1'b1;
            end else begin
               rem_in = rem_sh;
               qbit   = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (ce) begin
               n_ff    <= {n_s[l][k][NW-2:0], qbit};
               rem_ff  <= rem_in;
               d_ff    <= d_s[l][k];
               neg_ff  <= neg_s[l][k];
               zero_ff <= zero_s[l][k];
            end
         end

         assign n_s[l][k+1]    = n_ff;
         assign rem_s[l][k+1]  = rem_ff;
         assign d_s[l][k+1]    = d_ff;
         assign neg_s[l][k+1]  = neg_ff;
         assign zero_s[l][k+1] = zero_ff;
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_ctl
      item_type item_ff;
      logic     v_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (ce) begin
            v_ff <= v_s[k];
         end
         if (ce) begin
            item_ff <= item_s[k];
         end
      end

      assign item_s[k+1] = item_ff;
      assign v_s[k+1]    = v_ff;
   end

   always_comb begin
      word_type q;
      out_item = item_s[NW];
      for (int l = 0; l < LANES; l++) begin
         q = n_s[l][NW][WORD_W-1:0];
         if (zero_s[l][NW]) begin
            out_item.quot[l] = '0;
         end else if (neg_s[l][NW]) begin
            out_item.quot[l] = -q;
         end else begin
            out_item.quot[l] = q;
         end
         out_item.dzl[l] = zero_s[l][NW];
      end
   end
   assign out_valid = v_s[NW];

endmodule

### rtl/core/fixed_point_vec3_alu_top.sv
// Top level of the 20.12 fixed-point three-component vector ALU: multiply,
// square-root and divide pipelines plus the result register. Depends on
// fpv_pkg, fpv_if, fpv_mult, fpv_sqrt and fpv_div.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        func, a_x..a_z, b_x..b_z, scalar_operand
//   rsp_chan  out        valid/ready        r_x, r_y, r_z, scalar_result, div_zero
//
// One item enters per cycle while the result register is empty or being taken. The
// root and quotient pipelines resolve one bit per stage. Reset clears every valid
// bit; data registers are not reset.
// When a result waits untaken the whole pipeline holds and req_chan.ready is low.
module fixed_point_vec3_alu_top #(
   parameter int FRAC_BITS = fpv_pkg::FRAC_BITS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   fpv_req_if.sink   req_chan,
   fpv_rsp_if.source rsp_chan
);
   import fpv_pkg::*;

   logic     ce;
   item_type req_item;
   logic     mv;
   item_type m_item;
   logic     sv;
   item_type s_item;
   logic     dv;
   item_type d_item;

   logic     out_valid_ff;
   word_type rx_in, ry_in, rz_in, sr_in;
   logic     dz_in;
   word_type rx_ff, ry_ff, rz_ff, sr_ff;
   logic     dz_ff;

   assign ce = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = ce;

   always_comb begin
      req_item      = '0;
      req_item.func = req_chan.func;
      req_item.a[0] = req_chan.a_x;
      req_item.a[1] = req_chan.a_y;
      req_item.a[2] = req_chan.a_z;
      req_item.b[0] = req_chan.b_x;
      req_item.b[1] = req_chan.b_y;
      req_item.b[2] = req_chan.b_z;
      req_item.s    = req_chan.scalar_operand;
   end

   fpv_mult #(.FRAC_BITS(FRAC_BITS)) u_mult (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(req_chan.valid), .in_item(req_item),
      .out_valid(mv), .out_item(m_item)
   );

   fpv_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(mv), .in_item(m_item),
      .out_valid(sv), .out_item(s_item)
   );

   fpv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .ce(ce),
      .in_valid(sv), .in_item(s_item),
      .out_valid(dv), .out_item(d_item)
   );

   always_comb begin
      rx_in = '0;
      ry_in = '0;
      rz_in = '0;
      sr_in = '0;
      dz_in = 1'b0;
      case (d_item.func) inside
         FN_ADD: begin
            rx_in = d_item.a[0] + d_item.b[0];
            ry_in = d_item.a[1] + d_item.b[1];
            rz_in = d_item.a[2] + d_item.b[2];
         end
         FN_SUB: begin
            rx_in = d_item.a[0] - d_item.b[0];
            ry_in = d_item.a[1] - d_item.b[1];
            rz_in = d_item.a[2] - d_item.b[2];
         end
         FN_SCALE, FN_MUL: begin
            rx_in = d_item.prod[0];
            ry_in = d_item.prod[1];
            rz_in = d_item.prod[2];
         end
         FN_DIV, FN_DIVS, FN_NORM: begin
            rx_in = d_item.quot[0];
            ry_in = d_item.quot[1];
            rz_in = d_item.quot[2];
            dz_in = |d_item.dzl;
         end
         FN_MAG2: begin
            sr_in = d_item.mag2;
         end
         FN_MAG: begin
            sr_in = d_item.root;
         end
         default: begin
            sr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ce) begin
         out_valid_ff <= dv;
      end
      if (ce) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         rz_ff <= rz_in;
         sr_ff <= sr_in;
         dz_ff <= dz_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.r_x           = rx_ff;
   assign rsp_chan.r_y           = ry_ff;
   assign rsp_chan.r_z           = rz_ff;
   assign rsp_chan.scalar_result = sr_ff;
   assign rsp_chan.div_zero      = dz_ff;

`ifndef SYNTHESIS
   a_hold_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input accepted while a result is held");

   a_dz_zero_lane: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.div_zero |->
         rsp_chan.r_x == 0 || rsp_chan.r_y == 0 || rsp_chan.r_z == 0)
      else $error("divide-by-zero flag without a zero component");

   a_scalar_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.scalar_result != 0 |->
         rsp_chan.r_x == 0 && rsp_chan.r_y == 0 && rsp_chan.r_z == 0 && !rsp_chan.div_zero)
      else $error("scalar result together with a vector result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");
`endif

endmodule

### tb/fixed_point_vec3_alu_tb_pkg.sv
// Shared types for the vector ALU testbench: request and result records.
// Depends on fpv_pkg.
package fixed_point_vec3_alu_tb_pkg;
   import fpv_pkg::*;

   typedef struct {
      logic [3:0]         func;
      logic signed [31:0] a [3];
      logic signed [31:0] b [3];
      logic signed [31:0] s;
   } vec_req_type;

   typedef struct {
      logic [31:0] r [3];
      logic [31:0] sr;
      logic        dz;
   } vec_rsp_type;
endpackage

### tb/fixed_point_vec3_alu_top_tb.sv
// Testbench for fixed_point_vec3_alu_top: drives directed and random vector items,
// predicts each result in fixed point and compares field by field. Depends on
// fpv_pkg, fpv_if, fixed_point_vec3_alu_tb_pkg and the RTL.
module fixed_point_vec3_alu_top_tb;
   import fpv_pkg::*;
   import fixed_point_vec3_alu_tb_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int LAT = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   fpv_req_if req_chan ();
   fpv_rsp_if rsp_chan ();

   fixed_point_vec3_alu_top dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   vec_req_type pending_items[$];
   vec_rsp_type expected_results[$];
   int mismatch_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   bit stimulus_done = 1'b0;
   int long_hold = 0;
   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;

   function automatic logic [31:0] fx_product(logic signed [31:0] x, logic signed [31:0] y);
      logic signed [63:0] p;
      p = 64'(x) * 64'(y);
      return 32'(p >>> FB);
   endfunction

   function automatic logic [31:0] fx_quotient(logic signed [31:0] n, logic signed [63:0] d,
                                               ref logic dz);
      logic signed [63:0] q;
      if (d == 0) begin
         dz = 1'b1;
         return 32'd0;
      end
      q = (64'(n) <<< FB) / d;
      return q[31:0];
   endfunction

   function automatic logic [31:0] floor_root(logic [31:0] v);
      logic [63:0] x, root, bitv;
      x = 64'(v) << FB;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root[31:0];
   endfunction

   function automatic vec_rsp_type vector_result(vec_req_type q);
      vec_rsp_type e;
      logic [31:0] m2;
      logic signed [63:0] m;
      logic dz;
      dz = 1'b0;
      for (int i = 0; i < 3; i++) e.r[i] = '0;
      e.sr = '0;
      m2 = fx_product(q.a[0], q.a[0]) + fx_product(q.a[1], q.a[1]) + fx_product(q.a[2], q.a[2]);
      case (q.func)
         FN_ADD:   for (int i = 0; i < 3; i++) e.r[i] = q.a[i] + q.b[i];
         FN_SUB:   for (int i = 0; i < 3; i++) e.r[i] = q.a[i] - q.b[i];
         FN_SCALE: for (int i = 0; i < 3; i++) e.r[i] = fx_product(q.a[i], q.s);
         FN_MUL:   for (int i = 0; i < 3; i++) e.r[i] = fx_product(q.a[i], q.b[i]);
         FN_DIV:   for (int i = 0; i < 3; i++) e.r[i] = fx_quotient(q.a[i], 64'(q.b[i]), dz);
         FN_DIVS:  for (int i = 0; i < 3; i++) e.r[i] = fx_quotient(q.a[i], 64'(q.s), dz);
         FN_MAG2:  e.sr = m2;
         FN_MAG:   e.sr = floor_root(m2);
         FN_NORM: begin
            m = 64'({32'd0, floor_root(m2)});
            for (int i = 0; i < 3; i++) e.r[i] = fx_quotient(q.a[i], m, dz);
         end
         default: ;
      endcase
      e.dz = dz;
      return e;
   endfunction

   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'sd0;
         3, 4: return $signed(32'($urandom_range(0, 32'h3FFFF))) - 32'sh1FFFF;
         5, 6: return $signed(32'($urandom_range(0, 32'h7FFFFF))) - 32'sh3FFFFF;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic add_item(logic [3:0] f, logic signed [31:0] ax, logic signed [31:0] ay,
                           logic signed [31:0] az, logic signed [31:0] bx,
                           logic signed [31:0] by, logic signed [31:0] bz,
                           logic signed [31:0] s);
      vec_req_type q;
      q.func = f;
      q.a[0] = ax; q.a[1] = ay; q.a[2] = az;
      q.b[0] = bx; q.b[1] = by; q.b[2] = bz;
      q.s = s;
      pending_items.push_back(q);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH item %0d %s: got %h expected %h", checked_count, what, got, want);
      mismatch_count++;
   endtask

   initial begin
      logic signed [31:0] mx, mn;
      mx = 32'sh7FFFFFFF;
      mn = 32'sh80000000;
      add_item(FN_ADD, mx, mn, -1, 1, mn, -1, 0);
      add_item(FN_SUB, mn, mx, 0, 1, -1, mn, 0);
      add_item(FN_SCALE, mx, mn, 32'sh1000, 0, 0, 0, mn);
      add_item(FN_SCALE, -32'sh1800, 32'sh3000, 1, 0, 0, 0, mx);
      add_item(FN_MUL, mn, mx, -1, mn, mx, 1, 0);
      add_item(FN_MUL, -32'sh800, 32'sh1000, -32'sh1, 32'sh1, 32'sh2000, 32'sh1, 0);
      add_item(FN_DIV, mx, mn, 32'sh1000, 0, -1, 32'sh3000, 0);
      add_item(FN_DIV, mn, -32'sh7000, 5, -1, 32'sh2000, 0, 0);
      add_item(FN_DIVS, mx, mn, -32'sh1234, 0, 0, 0, 0);
      add_item(FN_DIVS, mx, mn, -32'sh1234, 0, 0, 0, -1);
      add_item(FN_DIVS, 32'sh5000, -32'sh3, 7, 0, 0, 0, 32'sh3000);
      add_item(FN_MAG2, 32'sh3000, 32'sh4000, 0, 1, 1, 1, 1);
      add_item(FN_MAG2, mx, mn, mx, 0, 0, 0, 0);
      add_item(FN_MAG, 32'sh3000, 32'sh4000, 0, 0, 0, 0, 0);
      add_item(FN_MAG, mx, mn, -1, 0, 0, 0, 0);
      add_item(FN_NORM, 32'sh3000, -32'sh4000, 32'sh1000, 0, 0, 0, 0);
      add_item(FN_NORM, 0, 0, 0, 1, 2, 3, 4);
      add_item(FN_NORM, mx, mn, 1, 0, 0, 0, 0);
      add_item(4'd9, 1, 2, 3, 4, 5, 6, 7);
      add_item(4'd15, mx, mn, -1, mx, mn, -1, mn);
      repeat (1950) begin
         add_item((($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8))),
                  random_word(), random_word(), random_word(),
                  random_word(), random_word(), random_word(), random_word());
      end
   end

   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.func <= '0;
         req_chan.a_x <= '0; req_chan.a_y <= '0; req_chan.a_z <= '0;
         req_chan.b_x <= '0; req_chan.b_y <= '0; req_chan.b_z <= '0;
         req_chan.scalar_operand <= '0;
      end else if (req_chan.valid && !req_taken) begin
      end else begin
         if (req_chan.valid) begin
            void'(pending_items.pop_front());
            send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
         end
         if (send_gap > 0 || pending_items.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_chan.valid <= 1'b0;
            if (pending_items.size() == 0 && sent_count > 0) stimulus_done = 1'b1;
         end else begin
            req_chan.valid <= 1'b1;
            req_chan.func <= pending_items[0].func;
            req_chan.a_x <= pending_items[0].a[0];
            req_chan.a_y <= pending_items[0].a[1];
            req_chan.a_z <= pending_items[0].a[2];
            req_chan.b_x <= pending_items[0].b[0];
            req_chan.b_y <= pending_items[0].b[1];
            req_chan.b_z <= pending_items[0].b[2];
            req_chan.scalar_operand <= pending_items[0].s;
         end
      end
   end

   always @(posedge clock) begin
      vec_req_type q;
      req_taken = !reset && req_chan.valid && req_chan.ready;
      if (req_taken) begin
         q.func = req_chan.func;
         q.a[0] = req_chan.a_x; q.a[1] = req_chan.a_y; q.a[2] = req_chan.a_z;
         q.b[0] = req_chan.b_x; q.b[1] = req_chan.b_y; q.b[2] = req_chan.b_z;
         q.s = req_chan.scalar_operand;
         expected_results.push_back(vector_result(q));
         sent_count++;
      end
   end

   int recv_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (sent_count >= 300 && long_hold == 0) begin
         long_hold = 1;
         recv_gap = 200;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_taken) begin
         recv_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
         rsp_chan.ready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_chan.ready <= (recv_gap == 0);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      vec_rsp_type e;
      rsp_taken = !reset && rsp_chan.valid && rsp_chan.ready;
      if (rsp_taken) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item", rsp_chan.r_x, '0);
         end else begin
            e = expected_results.pop_front();
            if (rsp_chan.r_x !== e.r[0]) report_mismatch("r_x", rsp_chan.r_x, e.r[0]);
            if (rsp_chan.r_y !== e.r[1]) report_mismatch("r_y", rsp_chan.r_y, e.r[1]);
            if (rsp_chan.r_z !== e.r[2]) report_mismatch("r_z", rsp_chan.r_z, e.r[2]);
            if (rsp_chan.scalar_result !== e.sr)
               report_mismatch("scalar_result", rsp_chan.scalar_result, e.sr);
            if (rsp_chan.div_zero !== e.dz)
               report_mismatch("div_zero", 32'(rsp_chan.div_zero), 32'(e.dz));
         end
         checked_count++;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LAT) @(posedge clock);
      if (expected_results.size() != 0) mismatch_count++;
      $display("Sent %0d vector items over all nine operations and unused codes,", sent_count);
      $display("checked %0d results, including a long receiver stall.", checked_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Timeout waiting for results.");
      $display("Mismatches found");
      $finish;
   end
endmodule
